// File: hdl/cwe_pkg.sv
package cwe_pkg;

    // Ring and sector geometry
    localparam int HISTORY_DEPTH = 64;
    localparam int PTR_W         = $clog2(HISTORY_DEPTH);
    localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);
    localparam int SECTOR_COUNT  = 8;
    localparam int SECT_W        = $clog2(SECTOR_COUNT);
    localparam int COV_W         = $clog2(SECTOR_COUNT + 1);
    localparam int MIN_SAMPLES   = 4;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_WIND  = 2'd2;

    localparam logic [15:0] MIN_SPEED_RST = 16'd768;
    localparam logic [31:0] WINDOW_RST    = 32'd60000;
    localparam logic [15:0] MAX_WIND_RST  = 16'd6400;

    // Input beat
    typedef struct packed {
        logic        is_flying;
        logic        gps_fix;
        logic        values_finite;
        logic [31:0] fix_sequence;
        logic [15:0] ground_speed;
        logic [15:0] track_angle;
        logic [31:0] time_ms;
    } in_t;

    // Result beat
    typedef struct packed {
        logic [15:0] wind_speed;
        logic [15:0] wind_direction;
        logic [3:0]  sectors_covered;
        logic        estimate_updated;
    } out_t;

    // One history entry
    typedef struct packed {
        logic [15:0] speed;
        logic [15:0] track;
        logic [31:0] stamp;
    } sample_t;

    // Controller to datapath
    typedef struct packed {
        logic load_in;
        logic decide;
        logic walk;
        logic finish;
        logic out_load;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic store;
        logic walk_done;
    } dp_status_t;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_DECIDE = 5'b00010,
        ST_WALK   = 5'b00100,
        ST_FINISH = 5'b01000,
        ST_DONE   = 5'b10000
    } state_t;

endpackage

// File: hdl/circling_wind_estimator.sv
// Sequence: a taken beat is latched and decided. When no sample is stored, the
// result is loaded from the held estimate. When one is stored, it is written to
// the ring, the ring is walked from its oldest entry, and the estimate is
// published if enough entries lie in the window before the result is loaded.
// Output stalls delay that load. Throughput: one beat in flight, the next taken
// after the load; a walk reads one ring entry per cycle via the single read port.
// Reset: aresetn synchronous, active low; clears estimates, ring pointers and
// control; history RAM contents are not cleared and need no clearing pass.
module circling_wind_estimator (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  cwe_pkg::in_t                   s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output cwe_pkg::out_t                  m_data,
    input  logic                           cfg_we,
    input  logic [cwe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cwe_pkg::CFG_DATA_W-1:0] cfg_data
);

    cwe_pkg::ctrl_cmd_t  cmd;
    cwe_pkg::dp_status_t status;

    cwe_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .status (status),
        .cmd    (cmd)
    );

    cwe_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_data   (s_data),
        .m_data   (m_data),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .status   (status)
    );

`ifndef SYNTHESIS
    // Block is busy right after taking a beat
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while previous beat still in work");

    // Estimate is published only after the walk pipeline has drained
    a_finish_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> status.walk_done)
        else $error("finish issued with ring reads still in flight");

    // Result register is never overwritten while its beat is pending
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid || m_ready))
        else $error("result overwritten before it was taken");
`endif

endmodule

// File: hdl/cwe_ram.sv
module cwe_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/cwe_ctrl.sv
module cwe_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  cwe_pkg::dp_status_t status,
    output cwe_pkg::ctrl_cmd_t  cmd
);

    cwe_pkg::state_t state_reg, state_next;
    logic            m_valid_reg, m_valid_next;

    // Sequencer: accept, decide, walk the ring, finish, hand off result
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            cwe_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = cwe_pkg::ST_DECIDE;
                end
            end
            cwe_pkg::ST_DECIDE: begin
                cmd.decide = 1'b1;
                state_next = status.store ? cwe_pkg::ST_WALK : cwe_pkg::ST_DONE;
            end
            cwe_pkg::ST_WALK: begin
                cmd.walk = 1'b1;
                if (status.walk_done) begin
                    state_next = cwe_pkg::ST_FINISH;
                end
            end
            cwe_pkg::ST_FINISH: begin
                cmd.finish = 1'b1;
                state_next = cwe_pkg::ST_DONE;
            end
            cwe_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = cwe_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = cwe_pkg::ST_IDLE;
            end
        endcase
    end

    // Output beat flag
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= cwe_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// File: hdl/cwe_datapath.sv
module cwe_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  cwe_pkg::in_t                        s_data,
    output cwe_pkg::out_t                       m_data,
    input  logic                                cfg_we,
    input  logic [cwe_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [cwe_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  cwe_pkg::ctrl_cmd_t                  cmd,
    output cwe_pkg::dp_status_t                 status
);

    // Configuration
    logic [15:0] min_speed_reg;
    logic [31:0] window_reg;
    logic [15:0] max_wind_reg;

    // Latched input beat and result
    cwe_pkg::in_t  in_reg;
    cwe_pkg::out_t out_reg;

    // Tracking state
    logic                      was_flying_reg;
    logic                      have_seq_reg;
    logic [31:0]               prev_seq_reg;
    logic [cwe_pkg::PTR_W-1:0] head_reg;
    logic [cwe_pkg::CNT_W-1:0] count_reg;
    logic [15:0]               spd_est_reg;
    logic [15:0]               dir_est_reg;
    logic [3:0]                conf_reg;
    logic                      updated_reg;

    // Walk pipeline
    logic [cwe_pkg::PTR_W-1:0] rd_ptr_reg;
    logic [cwe_pkg::CNT_W-1:0] issue_left_reg;
    logic                      p1_vld_reg;
    logic                      s2_vld_reg;
    logic                      s2_ok_reg;
    logic [15:0]               s2_speed_reg;
    logic [15:0]               s2_track_reg;

    // Accumulators
    logic [cwe_pkg::CNT_W-1:0]     considered_reg;
    logic [15:0]                   lo_reg;
    logic [15:0]                   hi_reg;
    logic [15:0]                   dir_lo_reg;
    logic [cwe_pkg::SECTOR_COUNT-1:0] seen_reg;

    // Combinational helpers
    logic                      seq_new;
    logic                      store;
    logic [cwe_pkg::PTR_W-1:0] head_inc;
    logic [cwe_pkg::CNT_W-1:0] count_inc;
    logic [cwe_pkg::CNT_W:0]   start_sum;
    logic [cwe_pkg::PTR_W-1:0] start_ptr;
    logic [cwe_pkg::PTR_W-1:0] rd_ptr_inc;
    logic                      issue;
    cwe_pkg::sample_t          wr_sample;
    cwe_pkg::sample_t          rd_sample;
    logic [31:0]               age;
    logic [31:0]               sect_prod;
    logic [cwe_pkg::SECT_W-1:0] sector;
    logic [cwe_pkg::COV_W-1:0] covered;
    logic [15:0]               half_spread;
    logic [3:0]                conf_sat;

    // Store decision for the latched beat
    always_comb begin
        seq_new = !(have_seq_reg && (in_reg.fix_sequence == prev_seq_reg));
        store   = in_reg.is_flying && seq_new && in_reg.gps_fix && in_reg.values_finite
                  && (in_reg.ground_speed >= min_speed_reg);
    end

    // Ring pointers; walk starts at the oldest entry after this write
    always_comb begin
        if (head_reg == cwe_pkg::PTR_W'(cwe_pkg::HISTORY_DEPTH - 1)) begin
            head_inc = '0;
        end else begin
            head_inc = head_reg + 1'b1;
        end
        if (count_reg == cwe_pkg::CNT_W'(cwe_pkg::HISTORY_DEPTH)) begin
            count_inc = count_reg;
        end else begin
            count_inc = count_reg + 1'b1;
        end
        if ((cwe_pkg::CNT_W+1)'(count_inc) > (cwe_pkg::CNT_W+1)'(head_inc)) begin
            start_sum = (cwe_pkg::CNT_W+1)'(head_inc)
                        + (cwe_pkg::CNT_W+1)'(cwe_pkg::HISTORY_DEPTH)
                        - (cwe_pkg::CNT_W+1)'(count_inc);
        end else begin
            start_sum = (cwe_pkg::CNT_W+1)'(head_inc) - (cwe_pkg::CNT_W+1)'(count_inc);
        end
        start_ptr = start_sum[cwe_pkg::PTR_W-1:0];
        if (rd_ptr_reg == cwe_pkg::PTR_W'(cwe_pkg::HISTORY_DEPTH - 1)) begin
            rd_ptr_inc = '0;
        end else begin
            rd_ptr_inc = rd_ptr_reg + 1'b1;
        end
    end

    assign issue = cmd.walk && (issue_left_reg != '0);

    assign wr_sample.speed = in_reg.ground_speed;
    assign wr_sample.track = in_reg.track_angle;
    assign wr_sample.stamp = in_reg.time_ms;

    cwe_ram #(
        .WIDTH($bits(cwe_pkg::sample_t)),
        .DEPTH(cwe_pkg::HISTORY_DEPTH)
    ) u_ring (
        .aclk (aclk),
        .we   (cmd.decide && store),
        .waddr(head_reg),
        .wdata(wr_sample),
        .re   (issue),
        .raddr(rd_ptr_reg),
        .rdata(rd_sample)
    );

    // Age check on the entry just read, sector of the staged entry
    always_comb begin
        age       = in_reg.time_ms - rd_sample.stamp;
        sect_prod = 32'(s2_track_reg) * 32'(cwe_pkg::SECTOR_COUNT);
        sector    = sect_prod[16 +: cwe_pkg::SECT_W];
    end

    // Final reduction: sectors visited and half spread
    always_comb begin
        covered = '0;
        for (int i = 0; i < cwe_pkg::SECTOR_COUNT; i++) begin
            covered = covered + cwe_pkg::COV_W'(seen_reg[i]);
        end
        if (32'(covered) > 32'd15) begin
            conf_sat = 4'd15;
        end else begin
            conf_sat = 4'(covered);
        end
        half_spread = (hi_reg - lo_reg) >> 1;
    end

    assign status.store     = store;
    assign status.walk_done = (issue_left_reg == '0) && !p1_vld_reg && !s2_vld_reg;

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_reg <= s_data;
        end
        if (cmd.out_load) begin
            out_reg.wind_speed       <= spd_est_reg;
            out_reg.wind_direction   <= dir_est_reg;
            out_reg.sectors_covered  <= conf_reg;
            out_reg.estimate_updated <= updated_reg;
        end
        if (cmd.decide && store) begin
            rd_ptr_reg <= start_ptr;
        end else if (issue) begin
            rd_ptr_reg <= rd_ptr_inc;
        end
        if (p1_vld_reg) begin
            s2_ok_reg    <= (age <= window_reg);
            s2_speed_reg <= rd_sample.speed;
            s2_track_reg <= rd_sample.track;
        end
        if (s2_vld_reg && s2_ok_reg) begin
            if ((considered_reg == '0) || (s2_speed_reg < lo_reg)) begin
                lo_reg     <= s2_speed_reg;
                dir_lo_reg <= s2_track_reg;
            end
            if ((considered_reg == '0) || (s2_speed_reg > hi_reg)) begin
                hi_reg <= s2_speed_reg;
            end
        end
    end

    // Control and estimate state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_speed_reg  <= cwe_pkg::MIN_SPEED_RST;
            window_reg     <= cwe_pkg::WINDOW_RST;
            max_wind_reg   <= cwe_pkg::MAX_WIND_RST;
            was_flying_reg <= 1'b0;
            have_seq_reg   <= 1'b0;
            prev_seq_reg   <= '0;
            head_reg       <= '0;
            count_reg      <= '0;
            spd_est_reg    <= '0;
            dir_est_reg    <= '0;
            conf_reg       <= '0;
            updated_reg    <= 1'b0;
            issue_left_reg <= '0;
            p1_vld_reg     <= 1'b0;
            s2_vld_reg     <= 1'b0;
            considered_reg <= '0;
            seen_reg       <= '0;
        end else begin
            // register writes
            if (cfg_we) begin
                unique case (cfg_index)
                    cwe_pkg::REG_MIN_SPEED: min_speed_reg <= cfg_data[15:0];
                    cwe_pkg::REG_WINDOW:    window_reg    <= cfg_data[31:0];
                    cwe_pkg::REG_MAX_WIND:  max_wind_reg  <= cfg_data[15:0];
                    default: ;
                endcase
            end

            // flight / sequence bookkeeping
            if (cmd.decide) begin
                updated_reg <= store;
                if (!in_reg.is_flying) begin
                    if (was_flying_reg) begin
                        head_reg     <= '0;
                        count_reg    <= '0;
                        have_seq_reg <= 1'b0;
                        prev_seq_reg <= '0;
                        spd_est_reg  <= '0;
                        dir_est_reg  <= '0;
                    end
                    was_flying_reg <= 1'b0;
                    conf_reg       <= '0;
                end else begin
                    was_flying_reg <= 1'b1;
                    if (seq_new) begin
                        prev_seq_reg <= in_reg.fix_sequence;
                        have_seq_reg <= 1'b1;
                    end
                    if (store) begin
                        head_reg       <= head_inc;
                        count_reg      <= count_inc;
                        issue_left_reg <= count_inc;
                        considered_reg <= '0;
                        seen_reg       <= '0;
                    end
                end
            end

            // read issue and pipeline valids
            if (issue) begin
                issue_left_reg <= issue_left_reg - 1'b1;
            end
            p1_vld_reg <= issue;
            s2_vld_reg <= p1_vld_reg;

            // accumulate entries inside the window
            if (s2_vld_reg && s2_ok_reg) begin
                considered_reg   <= considered_reg + 1'b1;
                seen_reg[sector] <= 1'b1;
            end

            // publish estimate
            if (cmd.finish) begin
                if (considered_reg >= cwe_pkg::CNT_W'(cwe_pkg::MIN_SAMPLES)) begin
                    spd_est_reg <= (half_spread > max_wind_reg) ? max_wind_reg : half_spread;
                    dir_est_reg <= dir_lo_reg;
                    conf_reg    <= conf_sat;
                end else begin
                    conf_reg <= '0;
                end
            end
        end
    end

    assign m_data = out_reg;

endmodule
